// ----- sv/rsv_pkg.sv -----
// package for the redundant image scrub voter
// payload types, register indexes, action codes and fixed field widths
// no dependencies
package rsv_pkg;

	localparam int BYTE_W      = 8;
	localparam int CHUNK_W     = 14;
	localparam int IMAGE_W     = 19;
	localparam int CHUNK_IDX_W = 12;
	localparam int FIX_W       = 13;
	localparam int ACTION_W    = 2;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = IMAGE_W;

	localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(5120);
	localparam logic [IMAGE_W-1:0] IMAGE_RESET = IMAGE_W'(112356);
	localparam logic [FIX_W-1:0]   FIX_MAX     = {FIX_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_BYTES = 1'd1;

	localparam logic [ACTION_W-1:0] ACT_LEAVE  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_FROM_A = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FROM_B = 2'd2;

	typedef struct packed {
		logic [BYTE_W-1:0] copy_a_byte;
		logic [BYTE_W-1:0] copy_b_byte;
		logic [BYTE_W-1:0] flash_byte;
	} scan_item_t;

	typedef struct packed {
		logic [ACTION_W-1:0]    action;
		logic [CHUNK_IDX_W-1:0] chunk_index;
		logic [FIX_W-1:0]       corrections;
		logic                   image_done;
		logic                   rewritten;
	} verdict_item_t;

endpackage

// ----- sv/rsv_scan_if.sv -----
// byte triple channel of the scrub voter
// depends on rsv_pkg
interface rsv_scan_if import rsv_pkg::*; ();
	logic       valid;
	logic       ready;
	scan_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/rsv_verdict_if.sv -----
// chunk decision channel of the scrub voter
// depends on rsv_pkg
interface rsv_verdict_if import rsv_pkg::*; ();
	logic          valid;
	logic          ready;
	verdict_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ----- sv/rsv_cfg_regs.sv -----
// configuration registers of the scrub voter and their clamped limits
// depends on rsv_pkg
module rsv_cfg_regs import rsv_pkg::*; #(
	parameter int MAX_CHUNK = 8192,
	parameter int MAX_IMAGE = 262144,
	localparam int CW  = $clog2(MAX_CHUNK + 1),
	localparam int IW  = $clog2(MAX_IMAGE + 1),
	localparam int CLW = (CW > CHUNK_W) ? CW : CHUNK_W,
	localparam int ILW = (IW > IMAGE_W) ? IW : IMAGE_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic [CLW-1:0]        chunk_lim,
	output logic [ILW-1:0]        image_lim
);

	logic [CHUNK_W-1:0] chunk_bytes_q;
	logic [IMAGE_W-1:0] image_bytes_q;
	logic [CLW-1:0]     chunk_ext;
	logic [ILW-1:0]     image_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_bytes_q <= CHUNK_RESET;
			image_bytes_q <= IMAGE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CHUNK_BYTES: chunk_bytes_q <= cfg_data[CHUNK_W-1:0];
				REG_IMAGE_BYTES: image_bytes_q <= cfg_data[IMAGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign chunk_ext = CLW'(chunk_bytes_q);
	assign image_ext = ILW'(image_bytes_q);

	// zero reads as one, oversize saturates
	always_comb begin
		if (chunk_bytes_q == '0) begin
			chunk_lim = CLW'(1);
		end else if (chunk_ext > CLW'(MAX_CHUNK)) begin
			chunk_lim = CLW'(MAX_CHUNK);
		end else begin
			chunk_lim = chunk_ext;
		end
		if (image_bytes_q == '0) begin
			image_lim = ILW'(1);
		end else if (image_ext > ILW'(MAX_IMAGE)) begin
			image_lim = ILW'(MAX_IMAGE);
		end else begin
			image_lim = image_ext;
		end
	end

endmodule

// ----- sv/rsv_vote.sv -----
// per-chunk match tracking, similarity counts and two-of-three decision
// depends on rsv_pkg
module rsv_vote import rsv_pkg::*; #(
	parameter int MAX_CHUNK = 8192,
	parameter int MAX_IMAGE = 262144,
	localparam int CW  = $clog2(MAX_CHUNK + 1),
	localparam int IW  = $clog2(MAX_IMAGE + 1),
	localparam int CLW = (CW > CHUNK_W) ? CW : CHUNK_W,
	localparam int ILW = (IW > IMAGE_W) ? IW : IMAGE_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  scan_item_t    item,
	input  logic [CLW-1:0] chunk_lim,
	input  logic [ILW-1:0] image_lim,
	output logic          res_valid,
	output verdict_item_t res
);

	logic [CW-1:0]          chunk_pos_q;
	logic [IW-1:0]          image_pos_q;
	logic [CHUNK_IDX_W-1:0] chunk_num_q;
	logic                   agree_q;
	logic                   a_ok_q;
	logic                   b_ok_q;
	logic [CW-1:0]          sim_a_q;
	logic [CW-1:0]          sim_b_q;
	logic [FIX_W-1:0]       fix_q;

	logic                   eq_af;
	logic                   eq_bf;
	logic                   agree_n;
	logic                   a_ok_n;
	logic                   b_ok_n;
	logic [CW-1:0]          sim_a_n;
	logic [CW-1:0]          sim_b_n;
	logic [CW-1:0]          chunk_pos_n;
	logic [IW-1:0]          image_pos_n;
	logic                   chunk_end;
	logic                   done;
	logic [ACTION_W-1:0]    action;
	logic [FIX_W-1:0]       fix_n;

	assign eq_af       = item.copy_a_byte == item.flash_byte;
	assign eq_bf       = item.copy_b_byte == item.flash_byte;
	assign agree_n     = agree_q & (item.copy_a_byte == item.copy_b_byte);
	assign a_ok_n      = a_ok_q & eq_af;
	assign b_ok_n      = b_ok_q & eq_bf;
	assign sim_a_n     = sim_a_q + CW'(eq_af);
	assign sim_b_n     = sim_b_q + CW'(eq_bf);
	assign chunk_pos_n = chunk_pos_q + CW'(1);
	assign image_pos_n = image_pos_q + IW'(1);
	assign done        = ILW'(image_pos_n) >= image_lim;
	assign chunk_end   = (CLW'(chunk_pos_n) >= chunk_lim) | done;

	always_comb begin
		action = ACT_LEAVE;
		if (!agree_n) begin
			if (!a_ok_n && !b_ok_n) begin
				action = (sim_a_n <= sim_b_n) ? ACT_FROM_B : ACT_FROM_A;
			end
		end else if (!a_ok_n) begin
			action = ACT_FROM_A;
		end
	end

	assign fix_n = ((action != ACT_LEAVE) && (fix_q != FIX_MAX)) ? fix_q + FIX_W'(1) : fix_q;

	assign res_valid       = fire & chunk_end;
	assign res.action      = action;
	assign res.chunk_index = chunk_num_q;
	assign res.corrections = fix_n;
	assign res.image_done  = done;
	assign res.rewritten   = fix_n != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_pos_q <= '0;
			image_pos_q <= '0;
			chunk_num_q <= '0;
			agree_q     <= 1'b1;
			a_ok_q      <= 1'b1;
			b_ok_q      <= 1'b1;
			sim_a_q     <= '0;
			sim_b_q     <= '0;
			fix_q       <= '0;
		end else if (fire) begin
			if (chunk_end) begin
				chunk_pos_q <= '0;
				agree_q     <= 1'b1;
				a_ok_q      <= 1'b1;
				b_ok_q      <= 1'b1;
				sim_a_q     <= '0;
				sim_b_q     <= '0;
			end else begin
				chunk_pos_q <= chunk_pos_n;
				agree_q     <= agree_n;
				a_ok_q      <= a_ok_n;
				b_ok_q      <= b_ok_n;
				sim_a_q     <= sim_a_n;
				sim_b_q     <= sim_b_n;
			end
			if (done) begin
				image_pos_q <= '0;
				chunk_num_q <= '0;
				fix_q       <= '0;
			end else begin
				image_pos_q <= image_pos_n;
				if (chunk_end) begin
					chunk_num_q <= chunk_num_q + CHUNK_IDX_W'(1);
					fix_q       <= fix_n;
				end
			end
		end
	end

endmodule

// ----- sv/redundant_image_scrub_voter_core.sv -----
// top level of the redundant image scrub voter
// depends on rsv_pkg, rsv_scan_if, rsv_verdict_if, rsv_cfg_regs, rsv_vote
//
// usage:
// scan carries one byte position per transaction: the byte of backup copy A,
// of backup copy B and of live flash. bytes arrive in image order.
// verdict carries one decision per chunk: leave, rewrite from A, or rewrite
// from B, with the chunk index, running correction count, image end and the
// rewritten flag. positions inside a chunk give no transaction on verdict.
// cfg_we/cfg_index/cfg_data write chunk_bytes (index 0) and image_bytes
// (index 1); write them only while no bytes are in flight.
// throughput: one byte per cycle while the verdict sink does not stall, set
// by the single input register feeding the compare and count logic.
// a decision becomes valid on verdict when the byte that ends its chunk moves
// from the input register into the result register.
// reset clears all counters and flags and restores the register defaults
// 5120 and 112356.
// when the verdict sink stalls the result register holds; an empty input
// register still takes one byte, after which scan.ready stays low until the
// result is taken.
module redundant_image_scrub_voter_core import rsv_pkg::*; #(
	parameter int MAX_CHUNK = 8192,
	parameter int MAX_IMAGE = 262144
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rsv_scan_if.sink              scan,
	rsv_verdict_if.source         verdict
);

	localparam int CW  = $clog2(MAX_CHUNK + 1);
	localparam int IW  = $clog2(MAX_IMAGE + 1);
	localparam int CLW = (CW > CHUNK_W) ? CW : CHUNK_W;
	localparam int ILW = (IW > IMAGE_W) ? IW : IMAGE_W;

	logic [CLW-1:0] chunk_lim;
	logic [ILW-1:0] image_lim;
	logic           valid_s1;
	scan_item_t     item_s1;
	logic           out_free;
	logic           fire;
	logic           res_valid;
	verdict_item_t  res;
	logic           out_valid_q;
	verdict_item_t  out_q;

	rsv_cfg_regs #(
		.MAX_CHUNK(MAX_CHUNK),
		.MAX_IMAGE(MAX_IMAGE)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.chunk_lim(chunk_lim),
		.image_lim(image_lim)
	);

	assign out_free   = !out_valid_q || verdict.ready;
	assign fire       = valid_s1 && out_free;
	assign scan.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (scan.valid && scan.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan.valid && scan.ready) begin
			item_s1 <= scan.data;
		end
	end

	rsv_vote #(
		.MAX_CHUNK(MAX_CHUNK),
		.MAX_IMAGE(MAX_IMAGE)
	) u_vote (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (item_s1),
		.chunk_lim(chunk_lim),
		.image_lim(image_lim),
		.res_valid(res_valid),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign verdict.valid = out_valid_q;
	assign verdict.data  = out_q;

endmodule

// ----- sim/rsv_scrub_checker.sv -----
`timescale 1ns / 100ps
// checker for the redundant image scrub voter: watches the scan, verdict and config ports,
// predicts each chunk decision and compares it with the verdict transaction that arrives
// depends on rsv_pkg, rsv_scan_if, rsv_verdict_if
module rsv_scrub_checker import rsv_pkg::*; #(
	parameter int MAX_CHUNK = 8192,
	parameter int MAX_IMAGE = 262144
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	rsv_scan_if                   scan,
	rsv_verdict_if                verdict,
	output int                    fail_count,
	output int                    due_count
);

	logic [CHUNK_W-1:0]     chunk_reg;
	logic [IMAGE_W-1:0]     image_reg;
	logic [CHUNK_W-1:0]     chunk_pos;
	logic [IMAGE_W-1:0]     image_pos;
	logic [CHUNK_IDX_W-1:0] chunk_num;
	logic                   copies_agree;
	logic                   a_matches;
	logic                   b_matches;
	logic [CHUNK_W-1:0]     hits_a;
	logic [CHUNK_W-1:0]     hits_b;
	logic [FIX_W-1:0]       fix_cnt;

	verdict_item_t due_verdicts[$];
	verdict_item_t want;
	int            errs;

	task automatic start_chunk();
		chunk_pos    = '0;
		copies_agree = 1'b1;
		a_matches    = 1'b1;
		b_matches    = 1'b1;
		hits_a       = '0;
		hits_b       = '0;
	endtask

	task automatic vote_byte(input scan_item_t it);
		logic [CHUNK_W-1:0] c_lim;
		logic [IMAGE_W-1:0] i_lim;
		logic               ended;
		verdict_item_t      v;
		if (chunk_reg == '0)
			c_lim = CHUNK_W'(1);
		else if (chunk_reg > CHUNK_W'(MAX_CHUNK))
			c_lim = CHUNK_W'(MAX_CHUNK);
		else
			c_lim = chunk_reg;
		if (image_reg == '0)
			i_lim = IMAGE_W'(1);
		else if (image_reg > IMAGE_W'(MAX_IMAGE))
			i_lim = IMAGE_W'(MAX_IMAGE);
		else
			i_lim = image_reg;

		if (it.copy_a_byte != it.copy_b_byte)
			copies_agree = 1'b0;
		if (it.copy_a_byte == it.flash_byte)
			hits_a++;
		else
			a_matches = 1'b0;
		if (it.copy_b_byte == it.flash_byte)
			hits_b++;
		else
			b_matches = 1'b0;
		chunk_pos++;
		image_pos++;
		ended = (image_pos >= i_lim);
		if (chunk_pos >= c_lim || ended) begin
			v.action = ACT_LEAVE;
			if (!copies_agree) begin
				if (!a_matches && !b_matches)
					v.action = (hits_a <= hits_b) ? ACT_FROM_B : ACT_FROM_A;
			end else if (!a_matches) begin
				v.action = ACT_FROM_A;
			end
			if (v.action != ACT_LEAVE && fix_cnt != FIX_MAX)
				fix_cnt++;
			v.chunk_index = chunk_num;
			v.corrections = fix_cnt;
			v.image_done  = ended;
			v.rewritten   = (fix_cnt != '0);
			due_verdicts.push_back(v);
			start_chunk();
			chunk_num++;
			if (ended) begin
				image_pos = '0;
				chunk_num = '0;
				fix_cnt   = '0;
			end
		end
	endtask

	task automatic check_field(input string name, input int unsigned exp_v, input int unsigned act_v);
		if (exp_v != act_v) begin
			errs++;
			$display("%0t verdict %s mismatch: expected %0d actual %0d", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_reg = CHUNK_RESET;
			image_reg = IMAGE_RESET;
			start_chunk();
			image_pos = '0;
			chunk_num = '0;
			fix_cnt   = '0;
			due_verdicts.delete();
			errs = 0;
			fail_count <= 0;
			due_count  <= 0;
		end else begin
			if (scan.valid && scan.ready)
				vote_byte(scan.data);
			if (verdict.valid && verdict.ready) begin
				if (due_verdicts.size() == 0) begin
					errs++;
					$display("%0t unexpected verdict transaction: expected none actual %p",
						$time, verdict.data);
				end else begin
					want = due_verdicts.pop_front();
					check_field("action", want.action, verdict.data.action);
					check_field("chunk_index", want.chunk_index, verdict.data.chunk_index);
					check_field("corrections", want.corrections, verdict.data.corrections);
					check_field("image_done", want.image_done, verdict.data.image_done);
					check_field("rewritten", want.rewritten, verdict.data.rewritten);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_CHUNK_BYTES: chunk_reg = cfg_data[CHUNK_W-1:0];
					REG_IMAGE_BYTES: image_reg = cfg_data[IMAGE_W-1:0];
					default: ;
				endcase
			end
			fail_count <= errs;
			due_count  <= due_verdicts.size();
		end
	end

endmodule

// ----- sim/tb_redundant_image_scrub_voter_core.sv -----
`timescale 1ns / 100ps
// testbench top for redundant_image_scrub_voter_core: clock, reset, config writes,
// byte triple stimulus, verdict back-pressure, watchdog and final verdict
// depends on rsv_pkg, rsv_scan_if, rsv_verdict_if, rsv_scrub_checker and the core
module tb_redundant_image_scrub_voter_core;
	import rsv_pkg::*;

	localparam int MAX_CHUNK  = 8192;
	localparam int MAX_IMAGE  = 262144;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_LEN   = 300;

	typedef enum int {
		PAT_ANY, PAT_SAME, PAT_COPIES, PAT_A_FLASH, PAT_B_FLASH, PAT_SPLIT, PAT_NOISE, PAT_STUCK
	} pattern_e;

	typedef enum int {SINK_OPEN, SINK_RANDOM, SINK_STALL} sink_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  hold_req;
	int                    fails;
	int                    pending;
	int                    idle_run;

	rsv_scan_if    scan();
	rsv_verdict_if verdict();

	redundant_image_scrub_voter_core #(
		.MAX_CHUNK(MAX_CHUNK),
		.MAX_IMAGE(MAX_IMAGE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.scan(scan),
		.verdict(verdict)
	);

	rsv_scrub_checker #(
		.MAX_CHUNK(MAX_CHUNK),
		.MAX_IMAGE(MAX_IMAGE)
	) chk (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.scan(scan),
		.verdict(verdict),
		.fail_count(fails),
		.due_count(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			idle_run <= 0;
		end else if ((scan.valid && scan.ready) || (verdict.valid && verdict.ready)) begin
			idle_run <= 0;
		end else begin
			idle_run <= idle_run + 1;
			if (idle_run >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	task automatic send_item(input scan_item_t it);
		scan.valid <= 1'b1;
		scan.data  <= it;
		@(posedge clk);
		while (!scan.ready)
			@(posedge clk);
	endtask

	task automatic drain();
		scan.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [CHUNK_W-1:0] chunk_v, input logic [IMAGE_W-1:0] image_v);
		logic [CFG_DATA_W-1:0] word;
		word = CFG_DATA_W'($urandom);
		word[CHUNK_W-1:0] = chunk_v;
		cfg_we    <= 1'b1;
		cfg_index <= REG_CHUNK_BYTES;
		cfg_data  <= word;
		@(posedge clk);
		cfg_index <= REG_IMAGE_BYTES;
		cfg_data  <= image_v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic feed(input int n, input int seg_len, input bit gaps_on, input pattern_e forced);
		int          seg_left;
		int          burst_left;
		int          gap;
		pattern_e    kind;
		int unsigned pa;
		int unsigned pb;
		logic [7:0]  v;
		scan_item_t  it;
		seg_left   = 0;
		burst_left = $urandom_range(1, 24);
		kind       = PAT_SAME;
		pa         = 0;
		pb         = 0;
		for (int i = 0; i < n; i++) begin
			if (seg_left == 0) begin
				seg_left = seg_len;
				if (forced != PAT_ANY)
					kind = forced;
				else if ($urandom_range(0, 3) == 0)
					kind = PAT_SPLIT;
				else
					kind = pattern_e'($urandom_range(PAT_SAME, PAT_NOISE));
				pa = $urandom_range(0, 8);
				pb = $urandom_range(0, 8);
			end
			seg_left--;
			v = 8'($urandom);
			it.copy_a_byte = v;
			it.copy_b_byte = v;
			it.flash_byte  = v;
			case (kind)
				PAT_COPIES: begin
					if ($urandom_range(0, 7) == 0)
						it.flash_byte = 8'($urandom);
				end
				PAT_A_FLASH: begin
					if ($urandom_range(0, 7) >= pb)
						it.copy_b_byte = 8'($urandom);
				end
				PAT_B_FLASH: begin
					if ($urandom_range(0, 7) >= pa)
						it.copy_a_byte = 8'($urandom);
				end
				PAT_SPLIT: begin
					if ($urandom_range(0, 7) >= pa)
						it.copy_a_byte = 8'($urandom);
					if ($urandom_range(0, 7) >= pb)
						it.copy_b_byte = 8'($urandom);
				end
				PAT_NOISE: begin
					it.copy_a_byte = 8'($urandom);
					it.copy_b_byte = 8'($urandom);
					it.flash_byte  = 8'($urandom);
				end
				PAT_STUCK: it.flash_byte = ~v;
				default: ;
			endcase
			send_item(it);
			burst_left--;
			if (burst_left == 0) begin
				gap = gaps_on ? $urandom_range(0, 6) : 0;
				if (gap > 0) begin
					scan.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	// verdict sink: open, random or stalled stretches, plus one long hold on request
	initial begin : verdict_sink
		int         rx_left;
		sink_mode_e rx_mode;
		bit         hold_done;
		rx_left   = 0;
		rx_mode   = SINK_OPEN;
		hold_done = 1'b0;
		verdict.ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				verdict.ready <= 1'b0;
				repeat (HOLD_LEN) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (rx_left == 0) begin
					rx_mode = sink_mode_e'($urandom_range(SINK_OPEN, SINK_STALL));
					rx_left = (rx_mode == SINK_STALL) ? $urandom_range(1, 8) : $urandom_range(4, 40);
				end
				rx_left--;
				case (rx_mode)
					SINK_OPEN:   verdict.ready <= 1'b1;
					SINK_RANDOM: verdict.ready <= 1'($urandom_range(0, 1));
					default:     verdict.ready <= 1'b0;
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int                 r;
		logic [CHUNK_W-1:0] chunk_v;
		logic [IMAGE_W-1:0] image_v;
		int                 seg;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = REG_CHUNK_BYTES;
		cfg_data   = '0;
		hold_req   = 1'b0;
		scan.valid = 1'b0;
		scan.data  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// zero sizes: every byte is its own chunk and its own image
		set_config(CHUNK_W'(0), IMAGE_W'(0));
		send_item(scan_item_t'{8'h00, 8'h00, 8'h00});
		send_item(scan_item_t'{8'hFF, 8'hFF, 8'h00});
		send_item(scan_item_t'{8'h00, 8'hFF, 8'h00});
		send_item(scan_item_t'{8'hFF, 8'h00, 8'h00});
		send_item(scan_item_t'{8'h12, 8'h34, 8'h56});
		drain();

		// chunks of 4 with a short last chunk: vote for A, copies agree, tie to B
		set_config(CHUNK_W'(4), IMAGE_W'(10));
		send_item(scan_item_t'{8'h05, 8'h09, 8'h05});
		send_item(scan_item_t'{8'h05, 8'h09, 8'h05});
		send_item(scan_item_t'{8'h03, 8'h02, 8'h02});
		send_item(scan_item_t'{8'h07, 8'h08, 8'h09});
		send_item(scan_item_t'{8'hAA, 8'hAA, 8'hAA});
		send_item(scan_item_t'{8'hAA, 8'hAA, 8'h55});
		send_item(scan_item_t'{8'h00, 8'h00, 8'h00});
		send_item(scan_item_t'{8'hFF, 8'hFF, 8'hFF});
		send_item(scan_item_t'{8'h01, 8'h02, 8'h01});
		send_item(scan_item_t'{8'h03, 8'h04, 8'h04});
		drain();

		// oversized chunk register saturates: the image end closes the chunk
		set_config({CHUNK_W{1'b1}}, IMAGE_W'(200));
		feed(200, 50, 1'b1, PAT_ANY);
		drain();

		// one byte chunks, every one rewritten, under a saturated image size
		set_config(CHUNK_W'(1), {IMAGE_W{1'b1}});
		feed(250, 1, 1'b0, PAT_STUCK);
		drain();

		// shrink the image below the current position so the pass ends at once
		set_config(CHUNK_W'(64), IMAGE_W'(5));
		feed(3, 64, 1'b0, PAT_ANY);
		drain();

		for (int ph = 0; ph < 25; ph++) begin
			r = $urandom_range(0, 7);
			if (r == 0)
				chunk_v = CHUNK_W'(0);
			else if (r == 1)
				chunk_v = CHUNK_W'(64);
			else
				chunk_v = CHUNK_W'($urandom_range(1, 12));
			r = $urandom_range(0, 7);
			if (r == 0)
				image_v = IMAGE_W'(0);
			else if (r == 1)
				image_v = {IMAGE_W{1'b1}};
			else if (r == 2)
				image_v = IMAGE_W'(1);
			else
				image_v = IMAGE_W'($urandom_range(2, 90));
			if (ph == 12) begin
				chunk_v  = CHUNK_W'(2);
				hold_req = 1'b1;
			end
			seg = (chunk_v == '0) ? 1 : int'(chunk_v);
			set_config(chunk_v, image_v);
			if (ph == 12)
				feed(60, seg, 1'b0, PAT_ANY);
			else
				feed($urandom_range(10, 60), seg, $urandom_range(0, 3) != 0, PAT_ANY);
			drain();
		end

		repeat (10) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
